### rtl/fwmh_pkg.sv
// Shared constants and types for the four-way min-heap.
package fwmh_pkg;

	// Request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Completion status of one request
	typedef logic [1:0] status_t;

	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_POP_EMPTY = 2'd1;
	localparam status_t STAT_PUSH_FULL = 2'd2;

endpackage

### rtl/fwmh_if.sv
// Request and response channel interfaces for the four-way min-heap.
interface fwmh_req_if #(
	parameter int KEY_BITS = 32,
	parameter int TAG_BITS = 16
);
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [KEY_BITS-1:0] entry_key;
	logic [TAG_BITS-1:0] entry_tag;

	modport source (output valid, req_type, entry_key, entry_tag, input ready);
	modport sink   (input valid, req_type, entry_key, entry_tag, output ready);
endinterface

interface fwmh_rsp_if import fwmh_pkg::*; #(
	parameter int KEY_BITS = 32,
	parameter int TAG_BITS = 16,
	parameter int CNT_BITS = 9
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] root_key;
	logic [TAG_BITS-1:0] root_tag;
	logic [CNT_BITS-1:0] entry_total;
	logic                is_empty;
	status_t             status;

	modport source (output valid, root_key, root_tag, entry_total, is_empty, status,
		input ready);
	modport sink   (input valid, root_key, root_tag, entry_total, is_empty, status,
		output ready);
endinterface

### rtl/fwmh_store.sv
// Entry store of the heap: one write port and one registered read port.
module fwmh_store #(
	parameter int DEPTH    = 256,
	parameter int IDX_W    = 8,
	parameter int KEY_BITS = 32,
	parameter int TAG_BITS = 16
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  logic [KEY_BITS-1:0] wr_key,
	input  logic [TAG_BITS-1:0] wr_tag,
	input  logic [IDX_W-1:0]    rd_addr,
	output logic [KEY_BITS-1:0] rd_key,
	output logic [TAG_BITS-1:0] rd_tag
);

	logic [KEY_BITS-1:0] key_mem [DEPTH];
	logic [TAG_BITS-1:0] tag_mem [DEPTH];

	// Write one slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			tag_mem[wr_addr] <= wr_tag;
		end
	end

	// Read one slot, data valid the next cycle
	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_tag <= tag_mem[rd_addr];
	end

endmodule

### rtl/four_way_min_heap.sv
// Four-way min-heap priority queue: sequencer, shared comparator and result register.
//
//   channel | dir | payload                                          | word taken when
//   --------+-----+--------------------------------------------------+-------------------
//   req     | in  | req_type, entry_key, entry_tag                   | req.valid & ready
//   rsp     | out | root_key, root_tag, entry_total, is_empty, status| rsp.valid & ready
//
// A push into an empty heap writes the entry directly; any other push reads the parent and
// compares once per level that the entry climbs, then writes the entry where it stops. A
// pop loads the last entry, then for each node reads its children one at a time (up to 4)
// and compares the smallest with the moving entry; popping the last entry needs no scan.
// These steps are set by the single read port of the entry store and the one shared key
// comparator.
// Reset clears the count and the sequencer; the store holds no reset value.
// req.ready is high only in idle; a finished word waits in the result register
// and a new request is taken meanwhile, but completes only once that word is gone.
module four_way_min_heap import fwmh_pkg::*; #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32,
	parameter int TAG_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	fwmh_req_if.sink     req,
	fwmh_rsp_if.source   rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = IDX_W + 3;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_UP_RD    = 3'd1;
	localparam logic [2:0] S_UP_CMP   = 3'd2;
	localparam logic [2:0] S_POP_LD   = 3'd3;
	localparam logic [2:0] S_DN_START = 3'd4;
	localparam logic [2:0] S_DN_SCAN  = 3'd5;
	localparam logic [2:0] S_DN_DEC   = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0]          state_q;
	logic                wr_cur_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [IDX_W-1:0]    last_q;
	logic [EXT_W-1:0]    issue_q;
	logic                best_vld_q;
	logic                rsp_vld_q;
	status_t             status_q;

	logic [KEY_BITS-1:0] cur_key_q, best_key_q, top_key_q, out_key_q;
	logic [TAG_BITS-1:0] cur_tag_q, best_tag_q, top_tag_q, out_tag_q;
	logic [CNT_W-1:0]    out_total_q;
	logic                out_empty_q;
	status_t             out_status_q;

	logic                req_fire;
	logic                out_free;
	logic [IDX_W-1:0]    parent_idx;
	logic [EXT_W-1:0]    first_ext, last_ext, count_ext, cnt_m1_ext, last_sel;
	logic                first_beyond;
	logic [KEY_BITS-1:0] cmp_a, cmp_b;
	logic                cmp_lt;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [KEY_BITS-1:0] wr_key;
	logic [TAG_BITS-1:0] wr_tag;
	logic [IDX_W-1:0]    rd_addr;
	logic [KEY_BITS-1:0] rd_key;
	logic [TAG_BITS-1:0] rd_tag;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !wr_cur_q;
	assign out_free  = !rsp_vld_q || rsp.ready;

	// Index arithmetic: parent, first child and last child in range
	assign parent_idx   = IDX_W'((pos_q - IDX_W'(1)) >> 2);
	assign first_ext    = EXT_W'({pos_q, 2'b01});
	assign last_ext     = first_ext + EXT_W'(3);
	assign count_ext    = EXT_W'(count_q);
	assign cnt_m1_ext   = count_ext - EXT_W'(1);
	assign last_sel     = (last_ext > cnt_m1_ext) ? cnt_m1_ext : last_ext;
	assign first_beyond = (first_ext >= count_ext);

	// Shared key comparator
	always_comb begin
		cmp_a = cur_key_q;
		cmp_b = rd_key;
		unique case (state_q)
			S_DN_SCAN: begin
				cmp_a = rd_key;
				cmp_b = best_key_q;
			end
			S_DN_DEC: begin
				cmp_a = cur_key_q;
				cmp_b = best_key_q;
			end
			default: ;
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	// Drive the store ports
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_key  = cur_key_q;
		wr_tag  = cur_tag_q;
		rd_addr = parent_idx;
		if (wr_cur_q) begin
			wr_en = 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire && req.req_type == REQ_PUSH && count_q == '0) begin
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_key  = req.entry_key;
						wr_tag  = req.entry_tag;
					end
					rd_addr = cnt_m1_ext[IDX_W-1:0];
				end
				S_UP_CMP: begin
					wr_en = 1'b1;
					if (cmp_lt) begin
						wr_key = rd_key;
						wr_tag = rd_tag;
					end
				end
				S_DN_START: rd_addr = first_ext[IDX_W-1:0];
				S_DN_SCAN:  rd_addr = issue_q[IDX_W-1:0];
				S_DN_DEC: begin
					wr_en = 1'b1;
					if (!cmp_lt) begin
						wr_key = best_key_q;
						wr_tag = best_tag_q;
					end
				end
				default: ;
			endcase
		end
	end

	fwmh_store #(
		.DEPTH    (CAPACITY),
		.IDX_W    (IDX_W),
		.KEY_BITS (KEY_BITS),
		.TAG_BITS (TAG_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_tag  (wr_tag),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_tag  (rd_tag)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wr_cur_q   <= 1'b0;
			count_q    <= '0;
			pos_q      <= '0;
			rd_idx_q   <= '0;
			best_idx_q <= '0;
			last_q     <= '0;
			issue_q    <= '0;
			best_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
			status_q   <= STAT_OK;
		end else begin
			// raise the result word on completion, drop it once taken
			if (state_q == S_DONE && !wr_cur_q && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (wr_cur_q) begin
				// place the moving entry, then finish
				wr_cur_q <= 1'b0;
				state_q  <= S_DONE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (req_fire) begin
							if (req.req_type == REQ_PUSH) begin
								if (count_q == CNT_MAX) begin
									status_q <= STAT_PUSH_FULL;
									state_q  <= S_DONE;
								end else begin
									status_q <= STAT_OK;
									pos_q    <= count_q[IDX_W-1:0];
									count_q  <= count_q + CNT_W'(1);
									state_q  <= (count_q == '0) ? S_DONE : S_UP_RD;
								end
							end else begin
								if (count_q == '0) begin
									status_q <= STAT_POP_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= STAT_OK;
									count_q  <= count_q - CNT_W'(1);
									pos_q    <= '0;
									state_q  <= (count_q == CNT_W'(1)) ? S_DONE : S_POP_LD;
								end
							end
						end
					end
					S_UP_RD: state_q <= S_UP_CMP;
					S_UP_CMP: begin
						// parent greater: move it down and climb
						if (cmp_lt) begin
							pos_q <= parent_idx;
							if (parent_idx == '0) begin
								wr_cur_q <= 1'b1;
							end else begin
								state_q <= S_UP_RD;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
					S_POP_LD: state_q <= S_DN_START;
					S_DN_START: begin
						if (first_beyond) begin
							wr_cur_q <= 1'b1;
						end else begin
							rd_idx_q   <= first_ext[IDX_W-1:0];
							issue_q    <= first_ext + EXT_W'(1);
							last_q     <= last_sel[IDX_W-1:0];
							best_vld_q <= 1'b0;
							state_q    <= S_DN_SCAN;
						end
					end
					S_DN_SCAN: begin
						// keep the leftmost smallest child; issue the next read
						if (!best_vld_q || cmp_lt) begin
							best_idx_q <= rd_idx_q;
						end
						best_vld_q <= 1'b1;
						if (issue_q <= EXT_W'(last_q)) begin
							rd_idx_q <= issue_q[IDX_W-1:0];
							issue_q  <= issue_q + EXT_W'(1);
						end else begin
							state_q <= S_DN_DEC;
						end
					end
					S_DN_DEC: begin
						if (cmp_lt) begin
							state_q <= S_DONE;
						end else begin
							pos_q   <= best_idx_q;
							state_q <= S_DN_START;
						end
					end
					S_DONE: begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// Entry registers: moving entry, best child and a copy of the root slot
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_fire) begin
			cur_key_q <= req.entry_key;
			cur_tag_q <= req.entry_tag;
		end else if (state_q == S_POP_LD && !wr_cur_q) begin
			cur_key_q <= rd_key;
			cur_tag_q <= rd_tag;
		end
		if (state_q == S_DN_SCAN && !wr_cur_q && (!best_vld_q || cmp_lt)) begin
			best_key_q <= rd_key;
			best_tag_q <= rd_tag;
		end
		if (wr_en && wr_addr == '0) begin
			top_key_q <= wr_key;
			top_tag_q <= wr_tag;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && !wr_cur_q && out_free) begin
			out_key_q    <= (count_q != '0) ? top_key_q : '0;
			out_tag_q    <= (count_q != '0) ? top_tag_q : '0;
			out_total_q  <= count_q;
			out_empty_q  <= (count_q == '0);
			out_status_q <= status_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.root_key    = out_key_q;
	assign rsp.root_tag    = out_tag_q;
	assign rsp.entry_total = out_total_q;
	assign rsp.is_empty    = out_empty_q;
	assign rsp.status      = out_status_q;

endmodule
